[rtl/dwvs_pkg.sv]
// ----------------------------------------------------------------------------
// dwvs_pkg
// Shared types and constants for the damped wave vertex step block.
// ----------------------------------------------------------------------------
`default_nettype none

package dwvs_pkg;

  localparam int DataWidth = 32;
  localparam int InWords   = 8;
  localparam int OutWords  = 3;
  localparam int InDataW   = InWords * DataWidth;
  localparam int OutDataW  = OutWords * DataWidth;
  localparam int PairW     = DataWidth + 1;

  localparam logic [1:0] RegTimeStep    = 2'd0;
  localparam logic [1:0] RegInvSpacingSq = 2'd1;
  localparam logic [1:0] RegCoupling    = 2'd2;
  localparam logic [1:0] RegDamping     = 2'd3;

  localparam logic [31:0] RstTimeStep     = 32'd65536;
  localparam logic [31:0] RstInvSpacingSq = 32'd65536;
  localparam logic [31:0] RstCoupling     = 32'd2147484;
  localparam logic [31:0] RstDamping      = 32'd2126008811;

  localparam logic [DataWidth-1:0] SatMax = {1'b0, {(DataWidth-1){1'b1}}};
  localparam logic [DataWidth-1:0] SatMin = {1'b1, {(DataWidth-1){1'b0}}};

  typedef struct packed {
    logic [31:0] time_step;
    logic [31:0] inv_spacing_sq;
    logic [31:0] coupling;
    logic [31:0] damping;
  } dwvs_cfg_t;

  typedef struct packed {
    logic [PairW-1:0]     pair_rl;
    logic [PairW-1:0]     pair_ud;
    logic [PairW-1:0]     pair_fb;
    logic [DataWidth-1:0] center;
    logic [DataWidth-1:0] vel_mag;
    logic                 vel_neg;
  } dwvs_word_t;

endpackage

`default_nettype wire

[rtl/damped_wave_vertex_step.sv]
// ----------------------------------------------------------------------------
// damped_wave_vertex_step
// Advance one vertex of a damped scalar wave by one Verlet time step.
//
//   channel  dir  handshake               payload
//   s_axis   in   s_axis_tvalid/tready    tdata: center, right, left, up,
//                                         down, front, back, velocity
//   m_axis   out  m_axis_tvalid/tready    tdata: field, velocity, accel;
//                                         tuser: saturated
//   cfg      in   cfg_we_i                cfg_idx_i, cfg_data_i
//
// One word in and one word out per cycle while the output is taken. Each
// word passes through the two-entry queue and the arithmetic pipeline, whose
// depth is set by the chain of registered multiplies. The pipeline holds
// while the output word is not taken; the queue keeps accepting until it is
// full. Reset loads the register defaults and empties the queue and pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module damped_wave_vertex_step (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // field_center, nb_right, nb_left, nb_up, nb_down, nb_front, nb_back,
  // velocity_in
  input  wire logic [dwvs_pkg::InDataW-1:0]  s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // field_out, velocity_out, accel_out
  output logic [dwvs_pkg::OutDataW-1:0]      m_axis_tdata,
  // saturated
  output logic [0:0]                         m_axis_tuser,
  input  wire logic                          cfg_we_i,
  input  wire logic [1:0]                    cfg_idx_i,
  input  wire logic [31:0]                   cfg_data_i
);
  import dwvs_pkg::*;

  dwvs_cfg_t  cfg_q;
  dwvs_word_t push_word, head_word;
  logic       q_full, q_push, q_valid, q_pop;
  logic [31:0] field_w, velocity_w, accel_w;
  logic        sat_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.time_step      <= RstTimeStep;
      cfg_q.inv_spacing_sq <= RstInvSpacingSq;
      cfg_q.coupling       <= RstCoupling;
      cfg_q.damping        <= RstDamping;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegTimeStep:     cfg_q.time_step      <= cfg_data_i;
        RegInvSpacingSq: cfg_q.inv_spacing_sq <= cfg_data_i;
        RegCoupling:     cfg_q.coupling       <= cfg_data_i;
        RegDamping:      cfg_q.damping        <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  dwvs_front u_front (
    .s_valid_i (s_axis_tvalid),
    .s_data_i  (s_axis_tdata),
    .s_ready_o (s_axis_tready),
    .q_full_i  (q_full),
    .q_push_o  (q_push),
    .q_word_o  (push_word)
  );

  dwvs_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (push_word),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .rdata_o (head_word)
  );

  dwvs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_word_i    (head_word),
    .q_pop_o     (q_pop),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .field_o     (field_w),
    .velocity_o  (velocity_w),
    .accel_o     (accel_w),
    .saturated_o (sat_w)
  );

  assign m_axis_tdata = {accel_w, velocity_w, field_w};
  assign m_axis_tuser = sat_w;

endmodule

`default_nettype wire

[rtl/dwvs_fifo.sv]
// ----------------------------------------------------------------------------
// dwvs_fifo
// Two-entry queue between the front and the back of the vertex step.
// ----------------------------------------------------------------------------
`default_nettype none

module dwvs_fifo (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire dwvs_pkg::dwvs_word_t wdata_i,
  output logic                     full_o,
  output logic                     valid_o,
  input  wire logic                pop_i,
  output dwvs_pkg::dwvs_word_t     rdata_o
);
  import dwvs_pkg::*;

  dwvs_word_t mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    cnt_d    = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  assign full_o  = cnt_q[1];
  assign valid_o = (cnt_q != 2'd0);
  assign rdata_o = mem_q[rd_ptr_q];

endmodule

`default_nettype wire

[rtl/dwvs_front.sv]
// ----------------------------------------------------------------------------
// dwvs_front
// Accept vertex words, pair up neighbors and split the velocity sign.
// ----------------------------------------------------------------------------
`default_nettype none

module dwvs_front (
  input  wire logic                          s_valid_i,
  input  wire logic [dwvs_pkg::InDataW-1:0]  s_data_i,
  output logic                               s_ready_o,
  input  wire logic                          q_full_i,
  output logic                               q_push_o,
  output dwvs_pkg::dwvs_word_t               q_word_o
);
  import dwvs_pkg::*;

  logic [DataWidth-1:0] center, nb_right, nb_left, nb_up, nb_down, nb_front, nb_back;
  logic [DataWidth-1:0] velocity_in;

  always_comb begin
    center      = s_data_i[0*DataWidth +: DataWidth];
    nb_right    = s_data_i[1*DataWidth +: DataWidth];
    nb_left     = s_data_i[2*DataWidth +: DataWidth];
    nb_up       = s_data_i[3*DataWidth +: DataWidth];
    nb_down     = s_data_i[4*DataWidth +: DataWidth];
    nb_front    = s_data_i[5*DataWidth +: DataWidth];
    nb_back     = s_data_i[6*DataWidth +: DataWidth];
    velocity_in = s_data_i[7*DataWidth +: DataWidth];

    q_word_o.pair_rl = {nb_right[DataWidth-1], nb_right} + {nb_left[DataWidth-1], nb_left};
    q_word_o.pair_ud = {nb_up[DataWidth-1], nb_up} + {nb_down[DataWidth-1], nb_down};
    q_word_o.pair_fb = {nb_front[DataWidth-1], nb_front} + {nb_back[DataWidth-1], nb_back};
    q_word_o.center  = center;
    q_word_o.vel_neg = velocity_in[DataWidth-1];
    q_word_o.vel_mag = velocity_in[DataWidth-1] ? (~velocity_in + 1'b1) : velocity_in;
  end

  assign s_ready_o = !q_full_i;
  assign q_push_o  = s_valid_i && !q_full_i;

endmodule

`default_nettype wire

[rtl/dwvs_back.sv]
// ----------------------------------------------------------------------------
// dwvs_back
// Sixteen-stage arithmetic pipeline: Laplacian, acceleration, Verlet update.
// ----------------------------------------------------------------------------
`default_nettype none

module dwvs_back (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire dwvs_pkg::dwvs_cfg_t  cfg_i,
  input  wire logic                 q_valid_i,
  input  wire dwvs_pkg::dwvs_word_t q_word_i,
  output logic                      q_pop_o,
  output logic                      m_valid_o,
  input  wire logic                 m_ready_i,
  output logic [31:0]               field_o,
  output logic [31:0]               velocity_o,
  output logic [31:0]               accel_o,
  output logic                      saturated_o
);
  import dwvs_pkg::*;

  localparam int NumStages = 16;

  logic                 en;
  logic [NumStages-1:0] vld_q;

  // stage 1
  logic [35:0] r1_t0_q, r1_t0_d, r1_t1_q, r1_t1_d;
  logic [31:0] r1_c_q, r1_vmag_q;
  logic        r1_vneg_q;
  // stage 2
  logic [35:0] r2_s_q;
  logic [63:0] r2_pvd_q;
  logic [31:0] r2_c_q;
  logic        r2_vneg_q;
  // stage 3
  logic [35:0] s_abs;
  logic [63:0] pvd_rnd;
  logic [34:0] r3_smag_q;
  logic        r3_sneg_q, r3_vneg_q;
  logic [32:0] r3_vdmag_q;
  logic [31:0] r3_c_q;
  // stage 4
  logic [66:0] r4_plap_q;
  logic [64:0] r4_pvdt_q;
  logic [33:0] r4_vd_q;
  logic        r4_sneg_q, r4_vneg_q;
  logic [31:0] r4_c_q;
  // stage 5
  logic [66:0] plap_rnd;
  logic [64:0] pvdt_rnd;
  logic [50:0] r5_lapmag_q;
  logic [48:0] r5_vdtmag_q;
  logic [33:0] r5_vd_q;
  logic        r5_sneg_q, r5_vneg_q;
  logic [31:0] r5_c_q;
  // stage 6
  logic [57:0] r6_pllo_q;
  logic [56:0] r6_plhi_q;
  logic [49:0] r6_vdt_q;
  logic [33:0] r6_vd_q;
  logic        r6_sneg_q;
  logic [31:0] r6_c_q;
  // stage 7
  logic [82:0] r7_pacc_q;
  logic [50:0] r7_cv_q;
  logic [33:0] r7_vd_q;
  logic        r7_sneg_q;
  // stage 8
  logic [82:0] pacc_rnd;
  logic [51:0] r8_armag_q;
  logic [50:0] r8_cv_q;
  logic [33:0] r8_vd_q;
  logic        r8_sneg_q;
  // stage 9
  logic        aclip_d;
  logic [31:0] amag_d;
  logic [31:0] r9_acc_q, r9_amag_q;
  logic        r9_aclip_q, r9_sneg_q;
  logic [50:0] r9_cv_q;
  logic [33:0] r9_vd_q;
  // stage 10
  logic [63:0] r10_pad_q;
  logic [31:0] r10_acc_q;
  logic        r10_aclip_q, r10_sneg_q;
  logic [50:0] r10_cv_q;
  logic [33:0] r10_vd_q;
  // stage 11
  logic [63:0] pad_rnd;
  logic [63:0] r11_pflo_q, r11_pfhi_q;
  logic [47:0] r11_avmag_q;
  logic [31:0] r11_acc_q;
  logic        r11_aclip_q, r11_sneg_q;
  logic [50:0] r11_cv_q;
  logic [33:0] r11_vd_q;
  // stage 12
  logic [95:0] r12_pf_q;
  logic [48:0] r12_av_q;
  logic [31:0] r12_acc_q;
  logic        r12_aclip_q, r12_sneg_q;
  logic [50:0] r12_cv_q;
  logic [33:0] r12_vd_q;
  // stage 13
  logic [95:0] pf_rnd;
  logic [62:0] r13_afmag_q;
  logic [49:0] r13_vel_q;
  logic [31:0] r13_acc_q;
  logic        r13_aclip_q, r13_sneg_q;
  logic [50:0] r13_cv_q;
  // stage 14
  logic        vclip_d;
  logic [31:0] vsat_d;
  logic [63:0] r14_af_q;
  logic [31:0] r14_vel_q, r14_acc_q;
  logic        r14_vclip_q, r14_aclip_q;
  logic [50:0] r14_cv_q;
  // stage 15
  logic [63:0] r15_fld_q;
  logic [31:0] r15_vel_q, r15_acc_q;
  logic        r15_clip_q;
  // stage 16
  logic        fclip_d;
  logic [31:0] fsat_d;
  logic [31:0] r16_fld_q, r16_vel_q, r16_acc_q;
  logic        r16_sat_q;

  assign en      = !vld_q[NumStages-1] || m_ready_i;
  assign q_pop_o = en && q_valid_i;

  always_comb begin
    r1_t0_d = {{3{q_word_i.pair_rl[PairW-1]}}, q_word_i.pair_rl}
            + {{3{q_word_i.pair_ud[PairW-1]}}, q_word_i.pair_ud};
    r1_t1_d = {{3{q_word_i.pair_fb[PairW-1]}}, q_word_i.pair_fb}
            - {{2{q_word_i.center[31]}}, q_word_i.center, 2'b00}
            - {{3{q_word_i.center[31]}}, q_word_i.center, 1'b0};

    s_abs    = r2_s_q[35] ? (~r2_s_q + 1'b1) : r2_s_q;
    pvd_rnd  = r2_pvd_q + 64'(33'h0_4000_0000);
    plap_rnd = r4_plap_q + 67'(17'h0_8000);
    pvdt_rnd = r4_pvdt_q + 65'(17'h0_8000);
    pacc_rnd = r7_pacc_q + 83'(33'h0_4000_0000);
    pad_rnd  = r10_pad_q + 64'(17'h0_8000);
    pf_rnd   = r12_pf_q + 96'(34'h1_0000_0000);

    if (r8_sneg_q) begin
      aclip_d = (r8_armag_q > 52'(33'h0_8000_0000));
      amag_d  = aclip_d ? SatMin : r8_armag_q[31:0];
    end else begin
      aclip_d = (r8_armag_q[51:31] != '0);
      amag_d  = aclip_d ? SatMax : r8_armag_q[31:0];
    end

    vclip_d = (r13_vel_q[49:31] != {19{r13_vel_q[49]}});
    vsat_d  = vclip_d ? (r13_vel_q[49] ? SatMin : SatMax) : r13_vel_q[31:0];

    fclip_d = (r15_fld_q[63:31] != {33{r15_fld_q[63]}});
    fsat_d  = fclip_d ? (r15_fld_q[63] ? SatMin : SatMax) : r15_fld_q[31:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NumStages-2:0], q_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      r1_t0_q   <= r1_t0_d;
      r1_t1_q   <= r1_t1_d;
      r1_c_q    <= q_word_i.center;
      r1_vmag_q <= q_word_i.vel_mag;
      r1_vneg_q <= q_word_i.vel_neg;

      r2_s_q    <= r1_t0_q + r1_t1_q;
      r2_pvd_q  <= 64'(r1_vmag_q) * 64'(cfg_i.damping);
      r2_c_q    <= r1_c_q;
      r2_vneg_q <= r1_vneg_q;

      r3_smag_q  <= s_abs[34:0];
      r3_sneg_q  <= r2_s_q[35];
      r3_vdmag_q <= pvd_rnd[63:31];
      r3_vneg_q  <= r2_vneg_q;
      r3_c_q     <= r2_c_q;

      r4_plap_q <= 67'(r3_smag_q) * 67'(cfg_i.inv_spacing_sq);
      r4_pvdt_q <= 65'(r3_vdmag_q) * 65'(cfg_i.time_step);
      r4_vd_q   <= r3_vneg_q ? (~{1'b0, r3_vdmag_q} + 1'b1) : {1'b0, r3_vdmag_q};
      r4_sneg_q <= r3_sneg_q;
      r4_vneg_q <= r3_vneg_q;
      r4_c_q    <= r3_c_q;

      r5_lapmag_q <= plap_rnd[66:16];
      r5_vdtmag_q <= pvdt_rnd[64:16];
      r5_vd_q     <= r4_vd_q;
      r5_sneg_q   <= r4_sneg_q;
      r5_vneg_q   <= r4_vneg_q;
      r5_c_q      <= r4_c_q;

      r6_pllo_q <= 58'(r5_lapmag_q[25:0]) * 58'(cfg_i.coupling);
      r6_plhi_q <= 57'(r5_lapmag_q[50:26]) * 57'(cfg_i.coupling);
      r6_vdt_q  <= r5_vneg_q ? (~{1'b0, r5_vdtmag_q} + 1'b1) : {1'b0, r5_vdtmag_q};
      r6_vd_q   <= r5_vd_q;
      r6_sneg_q <= r5_sneg_q;
      r6_c_q    <= r5_c_q;

      r7_pacc_q <= {25'd0, r6_pllo_q} + {r6_plhi_q, 26'd0};
      r7_cv_q   <= {{19{r6_c_q[31]}}, r6_c_q} + {r6_vdt_q[49], r6_vdt_q};
      r7_vd_q   <= r6_vd_q;
      r7_sneg_q <= r6_sneg_q;

      r8_armag_q <= pacc_rnd[82:31];
      r8_cv_q    <= r7_cv_q;
      r8_vd_q    <= r7_vd_q;
      r8_sneg_q  <= r7_sneg_q;

      r9_acc_q   <= r8_sneg_q ? (~amag_d + 1'b1) : amag_d;
      r9_amag_q  <= amag_d;
      r9_aclip_q <= aclip_d;
      r9_sneg_q  <= r8_sneg_q;
      r9_cv_q    <= r8_cv_q;
      r9_vd_q    <= r8_vd_q;

      r10_pad_q   <= 64'(r9_amag_q) * 64'(cfg_i.time_step);
      r10_acc_q   <= r9_acc_q;
      r10_aclip_q <= r9_aclip_q;
      r10_sneg_q  <= r9_sneg_q;
      r10_cv_q    <= r9_cv_q;
      r10_vd_q    <= r9_vd_q;

      r11_pflo_q  <= 64'(r10_pad_q[31:0]) * 64'(cfg_i.time_step);
      r11_pfhi_q  <= 64'(r10_pad_q[63:32]) * 64'(cfg_i.time_step);
      r11_avmag_q <= pad_rnd[63:16];
      r11_acc_q   <= r10_acc_q;
      r11_aclip_q <= r10_aclip_q;
      r11_sneg_q  <= r10_sneg_q;
      r11_cv_q    <= r10_cv_q;
      r11_vd_q    <= r10_vd_q;

      r12_pf_q    <= {32'd0, r11_pflo_q} + {r11_pfhi_q, 32'd0};
      r12_av_q    <= r11_sneg_q ? (~{1'b0, r11_avmag_q} + 1'b1) : {1'b0, r11_avmag_q};
      r12_acc_q   <= r11_acc_q;
      r12_aclip_q <= r11_aclip_q;
      r12_sneg_q  <= r11_sneg_q;
      r12_cv_q    <= r11_cv_q;
      r12_vd_q    <= r11_vd_q;

      r13_afmag_q <= pf_rnd[95:33];
      r13_vel_q   <= {{16{r12_vd_q[33]}}, r12_vd_q} + {r12_av_q[48], r12_av_q};
      r13_acc_q   <= r12_acc_q;
      r13_aclip_q <= r12_aclip_q;
      r13_sneg_q  <= r12_sneg_q;
      r13_cv_q    <= r12_cv_q;

      r14_af_q    <= r13_sneg_q ? (~{1'b0, r13_afmag_q} + 1'b1) : {1'b0, r13_afmag_q};
      r14_vel_q   <= vsat_d;
      r14_vclip_q <= vclip_d;
      r14_acc_q   <= r13_acc_q;
      r14_aclip_q <= r13_aclip_q;
      r14_cv_q    <= r13_cv_q;

      r15_fld_q  <= {{13{r14_cv_q[50]}}, r14_cv_q} + r14_af_q;
      r15_vel_q  <= r14_vel_q;
      r15_acc_q  <= r14_acc_q;
      r15_clip_q <= r14_vclip_q || r14_aclip_q;

      r16_fld_q <= fsat_d;
      r16_vel_q <= r15_vel_q;
      r16_acc_q <= r15_acc_q;
      r16_sat_q <= r15_clip_q || fclip_d;
    end
  end

  assign m_valid_o   = vld_q[NumStages-1];
  assign field_o     = r16_fld_q;
  assign velocity_o  = r16_vel_q;
  assign accel_o     = r16_acc_q;
  assign saturated_o = r16_sat_q;

endmodule

`default_nettype wire

[verif/vertex_step_checker.sv]
// ----------------------------------------------------------------------------
// vertex_step_checker
// Watches the input, output and register ports of the damped wave vertex
// step block. It predicts the field, velocity and acceleration of every
// accepted vertex word with its own copy of the registers, queues the
// predictions, and compares each output word, field by field, against the
// oldest one. It reports the mismatch count and the words still in flight.
// ----------------------------------------------------------------------------
module vertex_step_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_tvalid_i,
  input  logic                          in_tready_i,
  // field_center, nb_right, nb_left, nb_up, nb_down, nb_front, nb_back,
  // velocity_in
  input  logic [dwvs_pkg::InDataW-1:0]  in_tdata_i,
  input  logic                          out_tvalid_i,
  input  logic                          out_tready_i,
  // field_out, velocity_out, accel_out
  input  logic [dwvs_pkg::OutDataW-1:0] out_tdata_i,
  // saturated
  input  logic [0:0]                    out_tuser_i,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_idx_i,
  input  logic [31:0]                   cfg_data_i,
  output int                            mismatch_count_o,
  output int                            in_flight_o
);
  import dwvs_pkg::*;

  typedef struct packed {
    logic [31:0] field_out;
    logic [31:0] velocity_out;
    logic [31:0] accel_out;
    logic        saturated;
  } vertex_update_t;

  dwvs_cfg_t      coeffs;
  vertex_update_t expected_updates [$];
  vertex_update_t want;
  int             mismatches = 0;

  assign mismatch_count_o = mismatches;

  // round(value * factor / 2^shift), ties away from zero
  function automatic logic signed [127:0] scale_round(input logic signed [127:0] value,
                                                     input logic [31:0] factor,
                                                     input int unsigned shift);
    logic signed [127:0] prod;
    logic [127:0]        mag;
    prod = value * $signed({96'd0, factor});
    mag  = (prod < 0) ? -prod : prod;
    mag  = (mag + (128'd1 << (shift - 1))) >> shift;
    return (prod < 0) ? -$signed(mag) : $signed(mag);
  endfunction

  function automatic logic signed [31:0] clamp_q16(input logic signed [127:0] v);
    if (v > $signed(SatMax)) return SatMax;
    if (v < $signed(SatMin)) return SatMin;
    return v[31:0];
  endfunction

  function automatic vertex_update_t predict_vertex_step(input logic [InDataW-1:0] w);
    logic signed [127:0] centre, nb_sum, lap, acc_full, acc_ext, damped;
    logic signed [127:0] fld_full, vel_full;
    logic signed [31:0]  acc, fld, vel;
    vertex_update_t      upd;
    centre = $signed(w[31:0]);
    nb_sum = 0;
    for (int k = 1; k < 7; k++) nb_sum = nb_sum + $signed(w[32*k +: 32]);
    lap      = scale_round(nb_sum - 6 * centre, coeffs.inv_spacing_sq, 16);
    acc_full = scale_round(lap, coeffs.coupling, 31);
    acc      = clamp_q16(acc_full);
    acc_ext  = acc;
    damped   = scale_round($signed(w[255:224]), coeffs.damping, 31);
    fld_full = centre + scale_round(damped, coeffs.time_step, 16) +
               scale_round(acc_ext * $signed({96'd0, coeffs.time_step}),
                           coeffs.time_step, 33);
    vel_full = damped + scale_round(acc_ext, coeffs.time_step, 16);
    fld      = clamp_q16(fld_full);
    vel      = clamp_q16(vel_full);
    upd.field_out    = fld;
    upd.velocity_out = vel;
    upd.accel_out    = acc;
    upd.saturated    = (acc != acc_full) || (fld != fld_full) || (vel != vel_full);
    return upd;
  endfunction

  task automatic note_mismatch(input string what, input logic [31:0] exp_val,
                               input logic [31:0] got_val);
    mismatches++;
    if (mismatches <= 10)
      $display("ERROR: %s expected %h got %h at %0t", what, exp_val, got_val, $time);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coeffs = '{time_step: RstTimeStep, inv_spacing_sq: RstInvSpacingSq,
                 coupling: RstCoupling, damping: RstDamping};
      expected_updates.delete();
      in_flight_o <= 0;
    end else begin
      if (out_tvalid_i && out_tready_i) begin
        if (expected_updates.size() == 0) begin
          note_mismatch("unexpected word, field_out", 32'd0, out_tdata_i[31:0]);
        end else begin
          want = expected_updates.pop_front();
          if (out_tdata_i[31:0] !== want.field_out)
            note_mismatch("field_out", want.field_out, out_tdata_i[31:0]);
          if (out_tdata_i[63:32] !== want.velocity_out)
            note_mismatch("velocity_out", want.velocity_out, out_tdata_i[63:32]);
          if (out_tdata_i[95:64] !== want.accel_out)
            note_mismatch("accel_out", want.accel_out, out_tdata_i[95:64]);
          if (out_tuser_i[0] !== want.saturated)
            note_mismatch("saturated", {31'd0, want.saturated}, {31'd0, out_tuser_i[0]});
        end
      end
      if (in_tvalid_i && in_tready_i)
        expected_updates.push_back(predict_vertex_step(in_tdata_i));
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegTimeStep:     coeffs.time_step      = cfg_data_i;
          RegInvSpacingSq: coeffs.inv_spacing_sq = cfg_data_i;
          RegCoupling:     coeffs.coupling       = cfg_data_i;
          RegDamping:      coeffs.damping        = cfg_data_i;
          default: ;
        endcase
      end
      in_flight_o <= expected_updates.size();
    end
  end

endmodule

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the damped wave vertex step block. A directed set
// of vertex words covers the field extremes, rounding ties and saturation
// under several register settings; random words follow under a sweep of
// register settings and sender/receiver idling mixes. Results are predicted
// and checked by vertex_step_checker.
// ----------------------------------------------------------------------------
module testbench;
  import dwvs_pkg::*;

  localparam int ItemsPerSet = 180;
  localparam int NumSets     = 7;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [0:0]          m_axis_tuser;
  logic                cfg_we_i      = 1'b0;
  logic [1:0]          cfg_idx_i     = RegTimeStep;
  logic [31:0]         cfg_data_i    = '0;

  int mismatch_count;
  int in_flight;
  int idle_pct  = 0;
  int stall_pct = 0;

  damped_wave_vertex_step dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i
  );

  vertex_step_checker checker_i (
    .clk_i,
    .rst_ni,
    .in_tvalid_i      (s_axis_tvalid),
    .in_tready_i      (s_axis_tready),
    .in_tdata_i       (s_axis_tdata),
    .out_tvalid_i     (m_axis_tvalid),
    .out_tready_i     (m_axis_tready),
    .out_tdata_i      (m_axis_tdata),
    .out_tuser_i      (m_axis_tuser),
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .mismatch_count_o (mismatch_count),
    .in_flight_o      (in_flight)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) m_axis_tready <= ($urandom_range(99) >= stall_pct);

  function automatic logic [InDataW-1:0] pack_vertex(
      input logic [31:0] c, r, l, u, d, f, b, v);
    return {v, b, f, d, u, l, r, c};
  endfunction

  function automatic logic [31:0] pick_q16();
    case ($urandom_range(4))
      0, 1: return $urandom();
      2: return $urandom_range(32'h001F_FFFF) - 32'h0010_0000;
      default: begin
        case ($urandom_range(4))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          3: return 32'h0000_0001;
          default: return 32'hFFFF_FFFF;
        endcase
      end
    endcase
  endfunction

  function automatic logic [InDataW-1:0] random_vertex();
    logic [31:0]        centre;
    logic               smooth;
    logic [InDataW-1:0] w;
    centre = pick_q16();
    smooth = 1'($urandom_range(1));
    w[31:0] = centre;
    for (int k = 1; k < 7; k++)
      w[32*k +: 32] = smooth ? centre + ($urandom_range(32'h3FFFF) - 32'h20000) : pick_q16();
    w[255:224] = pick_q16();
    return w;
  endfunction

  task automatic offer_vertex(input logic [InDataW-1:0] w);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= w;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // hold the sender until every word in flight has come out
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (in_flight != 0) @(posedge clk_i);
  endtask

  task automatic load_coeffs(input logic [31:0] dt, iss, cpl, dmp);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= RegTimeStep;
    cfg_data_i <= dt;
    @(posedge clk_i);
    cfg_idx_i  <= RegInvSpacingSq;
    cfg_data_i <= iss;
    @(posedge clk_i);
    cfg_idx_i  <= RegCoupling;
    cfg_data_i <= cpl;
    @(posedge clk_i);
    cfg_idx_i  <= RegDamping;
    cfg_data_i <= dmp;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  initial begin
    int mode;
    int idle_tbl [4];
    int stall_tbl [4];
    idle_tbl  = '{0, 62, 0, 25};
    stall_tbl = '{0, 0, 62, 25};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset defaults: extremes of the fields
    offer_vertex(pack_vertex(0, 0, 0, 0, 0, 0, 0, 0));
    offer_vertex({8{32'h7FFF_FFFF}});
    offer_vertex({8{32'h8000_0000}});
    offer_vertex({{7{32'h7FFF_FFFF}}, 32'h8000_0000});
    offer_vertex({{7{32'h8000_0000}}, 32'h7FFF_FFFF});
    offer_vertex(pack_vertex(0, 1, 1, 1, 1, 1, 1, 32'hFFFF_FFFF));
    offer_vertex(pack_vertex(32'h0001_0000, 0, 0, 0, 0, 0, 0, 32'h0001_0000));
    drain();

    // all registers at their maximum: saturation everywhere
    load_coeffs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    offer_vertex({{7{32'h7FFF_FFFF}}, 32'h8000_0000});
    offer_vertex({{7{32'h8000_0000}}, 32'h7FFF_FFFF});
    offer_vertex(pack_vertex(0, 1, 0, 0, 0, 0, 0, 1));
    offer_vertex(pack_vertex(0, 0, 0, 0, 0, 0, 0, 0));
    drain();

    // half-scale coupling and damping: rounding ties in both directions
    load_coeffs(32'h0001_0000, 32'h0001_0000, 32'h4000_0000, 32'h4000_0000);
    offer_vertex(pack_vertex(0, 1, 0, 0, 0, 0, 0, 1));
    offer_vertex(pack_vertex(0, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 32'hFFFF_FFFF));
    offer_vertex(pack_vertex(0, 0, 0, 0, 0, 3, 0, 3));
    offer_vertex(pack_vertex(0, 0, 0, 32'hFFFF_FFFD, 0, 0, 0, 32'hFFFF_FFFD));
    offer_vertex({8{32'h7FFF_FFFF}});
    drain();

    // all registers zero
    load_coeffs(0, 0, 0, 0);
    offer_vertex(pack_vertex(32'h1234_5678, 1, 2, 3, 4, 5, 6, 32'h8000_0000));
    offer_vertex({8{32'h7FFF_FFFF}});
    drain();

    for (int set = 0; set < NumSets; set++) begin
      case (set)
        0: load_coeffs(RstTimeStep, RstInvSpacingSq, RstCoupling, RstDamping);
        1: load_coeffs(32'h0000_1000, 32'h0004_0000, 32'h8000_0000, 32'h8000_0000);
        2: load_coeffs($urandom(), $urandom(), $urandom(), $urandom());
        3: load_coeffs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        4: load_coeffs(1, 1, 1, 1);
        5: load_coeffs(32'h0001_0000, 32'h0001_0000, 32'h4000_0000, 32'h4000_0000);
        default: load_coeffs(0, 0, 0, 0);
      endcase
      for (int n = 0; n < ItemsPerSet; n++) begin
        mode      = (n / 45 + set) % 4;
        idle_pct  = idle_tbl[mode];
        stall_pct = stall_tbl[mode];
        offer_vertex(random_vertex());
      end
      drain();
    end

    repeat (40) @(posedge clk_i);
    if (mismatch_count == 0 && in_flight == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

[damped_wave_vertex_step.f]
rtl/dwvs_pkg.sv
rtl/dwvs_fifo.sv
rtl/dwvs_front.sv
rtl/dwvs_back.sv
rtl/damped_wave_vertex_step.sv
verif/vertex_step_checker.sv
verif/testbench.sv
